[rtl/core/hsfd_pkg.sv]
// Shared types, constants and helper functions for the humidity frame decoder.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package hsfd_pkg;

  // CRC-8 settings: poly x^8+x^5+x^4+1, MSB first, no final xor
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Fixed-point scaling: centi = floor(span * word / 65535) - offset
  localparam int unsigned TempSpan   = 17500;
  localparam int unsigned HumiSpan   = 10000;
  localparam int          TempOffset = 4500;
  localparam logic [15:0] WordMax    = 16'hFFFF;

  localparam int unsigned ProdW  = 31;  // 17500 * 65535 fits in 31 bits
  localparam int unsigned QuotW  = 15;  // quotient up to 17500
  localparam int unsigned TempCW = 15;
  localparam int unsigned HumiCW = 14;
  localparam int unsigned OutW   = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TEMP_FAIL = 2'd1,
    ST_HUMI_FAIL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  // one decoded frame, handed from the front to the scaling back end
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] humi_word;
    status_e     status;
  } frame_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535): x>>16 undershoots by at most one, remainder is low + q0
  function automatic logic [QuotW-1:0] div_word_max(logic [ProdW-1:0] x);
    logic [QuotW-1:0] q0;
    logic [16:0]      r0;
    q0 = x[ProdW-1:16];
    r0 = {1'b0, x[15:0]} + 17'(q0);
    if (r0 >= {1'b0, WordMax}) begin
      return q0 + QuotW'(1);
    end
    return q0;
  endfunction

endpackage

[rtl/core/humidity_sensor_frame_decoder_unit.sv]
// Humidity/temperature frame decoder, top level.
// Instantiates hsfd_front, hsfd_queue and hsfd_back; depends on hsfd_pkg.
`timescale 1ns / 1ps

// The block takes a six-byte sensor frame one byte per transaction (T high,
// T low, T check, H high, H low, H check) and, on the sixth byte, emits one
// transaction with both raw words, a status code and the values scaled to
// hundredths of a degree / percent. Check bytes are CRC-8 (poly 0x31, init
// 0xFF) over the two data bytes; a temperature mismatch is reported ahead of
// a humidity mismatch. tuser high restarts the frame at byte one and drops any
// partial frame; after byte six the position wraps, so frames may run back to
// back. Throughput is one byte per clock while s_axis_tready is high. After the
// sixth byte is accepted, the decoder writes the frame into a two-entry queue,
// then the scaling back end registers the multiplies and then the divide by
// 65535 into the output register. s_axis_tready drops only when that queue is
// full, i.e. when the master side has been stalled long enough to back the
// whole pipeline up.

module humidity_sensor_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [14:0] temp_centi, [28:15] humi_centi,
                                        // [44:29] temp_word, [60:45] humi_word,
                                        // [62:61] status, [63] zero
);
  import hsfd_pkg::*;

  // front -> queue
  logic   q_push;
  frame_t q_push_data;
  logic   q_ready;
  // queue -> back
  logic   q_pop_valid;
  frame_t q_pop_data;
  logic   q_pop_ready;

  // Front only advances when the queue can take a frame, so a stalled back
  // end throttles the byte stream instead of losing results.
  assign s_axis_tready_o = q_ready;

  hsfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .rx_byte_i     (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .in_ready_i    (q_ready),
    .push_valid_o  (q_push),
    .push_data_o   (q_push_data)
  );

  hsfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push),
    .push_data_i  (q_push_data),
    .push_ready_o (q_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_data_o   (q_pop_data),
    .pop_ready_i  (q_pop_ready)
  );

  hsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_pop_valid),
    .in_data_i   (q_pop_data),
    .in_ready_o  (q_pop_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_ready_i (m_axis_tready_i)
  );

  // A completed frame must never meet a full queue.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("frame pushed into full queue");

  // Divider correction keeps the scaled temperature in range.
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[14:0]) >= -15'sd4500 &&
                         $signed(m_axis_tdata_o[14:0]) <= 15'sd13000))
    else $error("temp_centi out of range");

  a_humi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[28:15] <= 14'd10000))
    else $error("humi_centi out of range");

  // The raw word out must match the scaled value: full-scale word, full scale.
  a_humi_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[60:45] == WordMax) |->
      (m_axis_tdata_o[28:15] == 14'd10000))
    else $error("humidity scaling mismatch at full scale");

endmodule

[rtl/core/hsfd_front.sv]
// Front end: tracks the byte position, runs the CRC-8 and assembles the words.
// Emits one frame_t per completed frame. Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_start_i,
  input  logic            in_ready_i,
  output logic            push_valid_o,
  output hsfd_pkg::frame_t push_data_o
);
  import hsfd_pkg::*;

  pos_e        pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_hold_q, temp_hold_d;
  logic [7:0]  humi_hi_q, humi_hi_d;
  logic [7:0]  humi_lo_q, humi_lo_d;
  logic        temp_good_q, temp_good_d;
  logic        fire;

  assign fire    = in_valid_i && in_ready_i;
  assign pos_eff = frame_start_i ? POS_T_HI : pos_q;

  always_comb begin
    crc_d       = crc_q;
    temp_hold_d = temp_hold_q;
    humi_hi_d   = humi_hi_q;
    humi_lo_d   = humi_lo_q;
    temp_good_d = temp_good_q;
    case (pos_eff)
      POS_T_LO: begin
        crc_d       = crc8_byte(crc_q, rx_byte_i);
        temp_hold_d = {temp_hold_q[15:8], rx_byte_i};
      end
      POS_T_CRC: begin
        temp_good_d = (crc_q == rx_byte_i);
      end
      POS_H_HI: begin
        crc_d     = crc8_byte(CrcInit, rx_byte_i);
        humi_hi_d = rx_byte_i;
      end
      POS_H_LO: begin
        crc_d     = crc8_byte(crc_q, rx_byte_i);
        humi_lo_d = rx_byte_i;
      end
      POS_H_CRC: begin
        // result only, nothing held changes
      end
      default: begin  // first byte of a frame
        crc_d       = crc8_byte(CrcInit, rx_byte_i);
        temp_hold_d = {rx_byte_i, 8'h00};
      end
    endcase
    pos_d = (pos_eff == POS_H_CRC) ? POS_T_HI : pos_e'(3'(pos_eff) + 3'd1);
  end

  always_comb begin
    push_valid_o          = fire && (pos_eff == POS_H_CRC);
    push_data_o.temp_word = temp_hold_q;
    push_data_o.humi_word = {humi_hi_q, humi_lo_q};
    if (!temp_good_q) begin
      push_data_o.status = ST_TEMP_FAIL;
    end else if (crc_q != rx_byte_i) begin
      push_data_o.status = ST_HUMI_FAIL;
    end else begin
      push_data_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_T_HI;
      crc_q       <= CrcInit;
      temp_hold_q <= '0;
      humi_hi_q   <= '0;
      humi_lo_q   <= '0;
      temp_good_q <= 1'b0;
    end else if (fire) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_hold_q <= temp_hold_d;
      humi_hi_q   <= humi_hi_d;
      humi_lo_q   <= humi_lo_d;
      temp_good_q <= temp_good_d;
    end
  end

endmodule

[rtl/core/hsfd_queue.sv]
// Two-entry queue of decoded frames between the front end and the back end.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  hsfd_pkg::frame_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output hsfd_pkg::frame_t pop_data_o,
  input  logic             pop_ready_i
);
  import hsfd_pkg::*;

  frame_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/core/hsfd_back.sv]
// Back end: scales the raw words to centi-units in two registered stages
// (multiply, then divide by 65535) and holds the result for the output bus.
// Depends on hsfd_pkg.
`timescale 1ns / 1ps

module hsfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  hsfd_pkg::frame_t in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [hsfd_pkg::OutW-1:0] out_data_o,
  input  logic             out_ready_i
);
  import hsfd_pkg::*;

  // product stage
  logic             s1_valid_q;
  logic [ProdW-1:0] tprod_q, hprod_q;
  frame_t           s1_frame_q;
  // output stage
  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q, out_data_d;

  logic             out_load, s1_load;
  logic [QuotW-1:0] tquot, hquot;
  logic [15:0]      temp_c;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_load;
  assign s1_load    = in_valid_i && in_ready_o;

  always_comb begin
    tquot  = div_word_max(tprod_q);
    hquot  = div_word_max(hprod_q);
    temp_c = {1'b0, tquot} - 16'(TempOffset);
    out_data_d = {1'b0,
                  s1_frame_q.status,
                  s1_frame_q.humi_word,
                  s1_frame_q.temp_word,
                  hquot[HumiCW-1:0],
                  temp_c[TempCW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      tprod_q    <= ProdW'(in_data_i.temp_word) * ProdW'(TempSpan);
      hprod_q    <= ProdW'(in_data_i.humi_word) * ProdW'(HumiSpan);
      s1_frame_q <= in_data_i;
    end
    if (out_load && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
